// ===== rtl/core/sdp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared widths, register map codes and the gain table of the surround
// delay processor.
// ----------------------------------------------------------------------------
package sdp_pkg;

  localparam int DELAY_DEPTH_DEF = 2400;

  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = 32;
  localparam int GAIN_W   = 18;
  localparam int COEF_W   = 12;
  localparam int SHIFT_W  = 6;
  localparam int REGNUM_W = 5;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Register map
  localparam logic [REGNUM_W-1:0] REG_LTAP_BASE = 5'd0;
  localparam logic [REGNUM_W-1:0] REG_RTAP_BASE = 5'd8;
  localparam logic [REGNUM_W-1:0] REG_VOL_BASE  = 5'd16;
  localparam logic [REGNUM_W-1:0] REG_COEF_BASE = 5'd20;
  localparam logic [REGNUM_W-1:0] REG_TAP_BASE  = 5'd22;
  localparam logic [REGNUM_W-1:0] REG_NONE      = 5'd31;

  // Signed gain: 2 dB attenuation table, bit 5 selects negative
  function automatic logic signed [GAIN_W-1:0] gain_lookup(input logic [SHIFT_W-1:0] d);
    logic [GAIN_W-1:0] g;
    case (d[4:0])
      5'd0:  g = 18'd0;
      5'd1:  g = 18'd64;
      5'd2:  g = 18'd81;
      5'd3:  g = 18'd102;
      5'd4:  g = 18'd128;
      5'd5:  g = 18'd162;
      5'd6:  g = 18'd204;
      5'd7:  g = 18'd257;
      5'd8:  g = 18'd324;
      5'd9:  g = 18'd408;
      5'd10: g = 18'd514;
      5'd11: g = 18'd648;
      5'd12: g = 18'd816;
      5'd13: g = 18'd1028;
      5'd14: g = 18'd1295;
      5'd15: g = 18'd1631;
      5'd16: g = 18'd2055;
      5'd17: g = 18'd2588;
      5'd18: g = 18'd3260;
      5'd19: g = 18'd4107;
      5'd20: g = 18'd5173;
      5'd21: g = 18'd6517;
      5'd22: g = 18'd8209;
      5'd23: g = 18'd10340;
      5'd24: g = 18'd13025;
      5'd25: g = 18'd16406;
      5'd26: g = 18'd20666;
      5'd27: g = 18'd26032;
      5'd28: g = 18'd32790;
      5'd29: g = 18'd41304;
      5'd30: g = 18'd52027;
      5'd31: g = 18'd65536;
      default: g = 18'd0;
    endcase
    return d[5] ? signed'(-g) : signed'(g);
  endfunction

endpackage

// ===== rtl/core/surround_delay_processor.sv =====
// ----------------------------------------------------------------------------
// surround_delay_processor
// Serial register port, mono delay line with feedback and eight stereo taps.
// ----------------------------------------------------------------------------
// A pin-write transaction is taken without leaving the idle state. A sample
// transaction runs through the feedback path and the delay line write, then
// the tap read, left, right and accumulate steps for each of the eight taps,
// then the output volumes; it is serial because of the single shared multiplier,
// used twice on each tap pass plus six more times, and the one read port of the delay memory.
// After reset the delay memory is cleared one entry per cycle, and no
// transaction is taken in that time. A finished result waits in the output
// register; the next sample is accepted meanwhile.
module surround_delay_processor import sdp_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [2:0]                 pin_bits_i,
  input  logic signed [SAMPLE_W-1:0] left_first_i,
  input  logic signed [SAMPLE_W-1:0] right_first_i,
  input  logic signed [SAMPLE_W-1:0] left_second_i,
  input  logic signed [SAMPLE_W-1:0] right_second_i,
  input  logic                       end_of_block_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] out_left_first_o,
  output logic signed [SAMPLE_W-1:0] out_right_first_o,
  output logic signed [SAMPLE_W-1:0] out_left_second_o,
  output logic signed [SAMPLE_W-1:0] out_right_second_o
);

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int OFF_W = $clog2(DELAY_DEPTH + 1);
  localparam int IW    = OFF_W + 1;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_RD0  = 4'd2;
  localparam logic [3:0] ST_FT   = 4'd3;
  localparam logic [3:0] ST_M1   = 4'd4;
  localparam logic [3:0] ST_M2   = 4'd5;
  localparam logic [3:0] ST_M3   = 4'd6;
  localparam logic [3:0] ST_M4   = 4'd7;
  localparam logic [3:0] ST_TRD  = 4'd8;
  localparam logic [3:0] ST_TL   = 4'd9;
  localparam logic [3:0] ST_TR   = 4'd10;
  localparam logic [3:0] ST_TA   = 4'd11;
  localparam logic [3:0] ST_V    = 4'd12;
  localparam logic [3:0] ST_VL   = 4'd13;
  localparam logic [3:0] ST_VR   = 4'd14;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [2:0]    tap_q;
  logic [AW-1:0] wp_q;

  logic signed [GAIN_W-1:0] ltap [8];
  logic signed [GAIN_W-1:0] rtap [8];
  logic signed [GAIN_W-1:0] vol  [4];
  logic signed [COEF_W-1:0] coef [2];
  logic [OFF_W-1:0]         off  [9];

  logic signed [SAMPLE_W-1:0] a_q, b_q, c_q, e_q;
  logic signed [DATA_W-1:0]   fhist_q, ftemp_q, t_q, fo2_q, accl_q, accr_q, sl_q;
  logic signed [DATA_W-1:0]   prevl_q, prevr_q, sr;
  logic signed [32:0]         accf_q;
  logic signed [MUL_A_W-1:0]  fout;

  logic signed [DATA_W-1:0] mem [DELAY_DEPTH];
  logic signed [DATA_W-1:0] rdata_q, wdata;
  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic signed [17:0]   sum4;
  logic signed [17:0]   mono;
  logic [3:0]           tap_sel;
  logic [IW-1:0]        offm, idx;
  logic                 in_acc, out_free;
  logic signed [32:0]   hl, hr;
  logic signed [SAMPLE_W-1:0] olf_q, orf_q, ols_q, ors_q;
  logic                 out_valid_q;

  sdp_regs #(.DELAY_DEPTH(DELAY_DEPTH), .OFF_W(OFF_W)) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_acc && !cmd_i),
    .pin_bits_i (pin_bits_i),
    .ltap_o     (ltap),
    .rtap_o     (rtap),
    .vol_o      (vol),
    .coef_o     (coef),
    .off_o      (off)
  );

  sdp_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !(out_valid_q && out_stall_i);

  // Mono average, truncated toward zero
  always_comb begin
    sum4 = 18'(a_q) + 18'(b_q) + 18'(c_q) + 18'(e_q);
    mono = (sum4 + (sum4[17] ? 18'sd3 : 18'sd0)) >>> 2;
  end

  // Tap address: wrap the offset once, then step back from the write slot
  always_comb begin
    tap_sel = (state_q == ST_RD0) ? 4'd0 : 4'({1'b0, tap_q} + 4'd1);
    offm    = IW'(off[tap_sel]);
    if (offm >= IW'(DELAY_DEPTH)) offm = offm - IW'(DELAY_DEPTH);
    if (IW'(wp_q) >= offm) begin
      idx = IW'(wp_q) - offm;
    end else begin
      idx = IW'(wp_q) + IW'(DELAY_DEPTH) - offm;
    end
    raddr = idx[AW-1:0];
    re    = (state_q == ST_RD0) || (state_q == ST_TRD);
  end

  // Delay memory write port: clearing pass or the new sample
  always_comb begin
    fout  = MUL_A_W'(accf_q) + MUL_A_W'(signed'(prod[43:11]));
    we    = (state_q == ST_CLR) || (state_q == ST_M4);
    waddr = (state_q == ST_CLR) ? clr_q : wp_q;
    wdata = (state_q == ST_CLR) ? '0 : signed'(prod[47:16] + fo2_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_FT: begin
        mul_a = MUL_A_W'(rdata_q);
        mul_b = MUL_B_W'(coef[0]);
      end
      ST_M1: begin
        mul_a = MUL_A_W'(fhist_q);
        mul_b = MUL_B_W'(coef[1]);
      end
      ST_M2: begin
        mul_a = fout;
        mul_b = vol[1];
      end
      ST_M3: begin
        mul_a = MUL_A_W'(mono);
        mul_b = vol[0];
      end
      ST_TL: begin
        mul_a = MUL_A_W'(rdata_q);
        mul_b = ltap[tap_q];
      end
      ST_TR: begin
        mul_a = MUL_A_W'(t_q);
        mul_b = rtap[tap_q];
      end
      ST_V: begin
        mul_a = MUL_A_W'(accl_q);
        mul_b = vol[2];
      end
      ST_VL, ST_VR: begin
        mul_a = MUL_A_W'(accr_q);
        mul_b = vol[3];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Output mix: first frame takes the mean of current and previous outputs
  always_comb begin
    sr = signed'(prod[46:15]);
    hl = 33'(sl_q) + 33'(prevl_q);
    hl = (hl + (hl[32] ? 33'sd1 : 33'sd0)) >>> 1;
    hr = 33'(sr) + 33'(prevr_q);
    hr = (hr + (hr[32] ? 33'sd1 : 33'sd0)) >>> 1;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_q == AW'(DELAY_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: if (in_acc && cmd_i) state_d = ST_RD0;
      ST_RD0:  state_d = ST_FT;
      ST_FT:   state_d = ST_M1;
      ST_M1:   state_d = ST_M2;
      ST_M2:   state_d = ST_M3;
      ST_M3:   state_d = ST_M4;
      ST_M4:   state_d = ST_TRD;
      ST_TRD:  state_d = ST_TL;
      ST_TL:   state_d = ST_TR;
      ST_TR:   state_d = ST_TA;
      ST_TA:   state_d = (tap_q == 3'd7) ? ST_V : ST_TRD;
      ST_V:    state_d = ST_VL;
      ST_VL:   state_d = ST_VR;
      ST_VR:   if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      tap_q       <= '0;
      wp_q        <= '0;
      fhist_q     <= '0;
      prevl_q     <= '0;
      prevr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) clr_q <= clr_q + AW'(1);
      if (state_q == ST_M4) tap_q <= '0;
      if (state_q == ST_TA) tap_q <= tap_q + 3'd1;
      // Drop the result once taken, unless a new one is committed now
      if (out_valid_q && !out_stall_i && !(state_q == ST_VR && out_free)) begin
        out_valid_q <= 1'b0;
      end
      // Commit the result and advance the per-sample state
      if (state_q == ST_VR && out_free) begin
        out_valid_q <= 1'b1;
        wp_q        <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
        fhist_q     <= ftemp_q;
        prevl_q     <= sl_q;
        prevr_q     <= sr;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && cmd_i) begin
      a_q <= left_first_i;
      b_q <= right_first_i;
      c_q <= left_second_i;
      e_q <= right_second_i;
    end
    case (state_q)
      ST_FT: ftemp_q <= rdata_q;
      ST_M1: accf_q  <= signed'(prod[43:11]);
      ST_M3: fo2_q   <= signed'(prod[47:16]);
      ST_M4: begin
        accl_q <= '0;
        accr_q <= '0;
      end
      ST_TL: t_q    <= rdata_q;
      ST_TR: accl_q <= accl_q + signed'(prod[47:16]);
      ST_TA: accr_q <= accr_q + signed'(prod[47:16]);
      ST_VL: sl_q   <= signed'(prod[46:15]);
      ST_VR: begin
        if (out_free) begin
          olf_q <= a_q + signed'(hl[15:0]);
          orf_q <= b_q + signed'(hr[15:0]);
          ols_q <= c_q + signed'(sl_q[15:0]);
          ors_q <= e_q + signed'(sr[15:0]);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign out_left_first_o   = olf_q;
  assign out_right_first_o  = orf_q;
  assign out_left_second_o  = ols_q;
  assign out_right_second_o = ors_q;

  // Assertions
  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_VR))
    else $error("result raised outside the final step");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i) |=> (state_q == ST_RD0))
    else $error("sample transaction did not start the sequence");

  a_pin_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !cmd_i) |=> (state_q == ST_IDLE))
    else $error("pin transaction left the sequencer busy");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < AW'(DELAY_DEPTH))
    else $error("write position out of range");

endmodule

// ===== rtl/core/sdp_regs.sv =====
// ----------------------------------------------------------------------------
// sdp_regs
// Three-pin serial register port: shift register, register number latch
// and the gain, volume, coefficient and tap position registers.
// ----------------------------------------------------------------------------
module sdp_regs import sdp_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int OFF_W       = $clog2(DELAY_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [2:0]               pin_bits_i,
  output logic signed [GAIN_W-1:0] ltap_o [8],
  output logic signed [GAIN_W-1:0] rtap_o [8],
  output logic signed [GAIN_W-1:0] vol_o  [4],
  output logic signed [COEF_W-1:0] coef_o [2],
  output logic [OFF_W-1:0]         off_o  [9]
);

  localparam int TAP_STEP = DELAY_DEPTH / 31;

  logic [SHIFT_W-1:0]  shift_q, shift_d, shifted;
  logic                clk_pin_q, sel_pin_q;
  logic [REGNUM_W-1:0] regnum_q, regnum_d;
  logic                load;

  logic signed [GAIN_W-1:0] ltap_q [8];
  logic signed [GAIN_W-1:0] rtap_q [8];
  logic signed [GAIN_W-1:0] vol_q  [4];
  logic signed [COEF_W-1:0] coef_q [2];
  logic [OFF_W-1:0]         off_q  [9];

  // Shift on a rising serial clock, then act on a select edge
  always_comb begin
    shifted  = (!clk_pin_q && pin_bits_i[1]) ? {shift_q[SHIFT_W-2:0], pin_bits_i[0]}
                                             : shift_q;
    shift_d  = shifted;
    regnum_d = regnum_q;
    load     = 1'b0;
    if (sel_pin_q != pin_bits_i[2]) begin
      if (!sel_pin_q) begin
        regnum_d = shifted[REGNUM_W-1:0];
      end else begin
        load = 1'b1;
      end
      shift_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= '0;
      clk_pin_q <= 1'b0;
      sel_pin_q <= 1'b0;
      regnum_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        ltap_q[i] <= '0;
        rtap_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) vol_q[i] <= '0;
      for (int i = 0; i < 2; i++) coef_q[i] <= '0;
      for (int i = 0; i < 9; i++) off_q[i] <= '0;
    end else if (wr_en_i) begin
      shift_q   <= shift_d;
      clk_pin_q <= pin_bits_i[1];
      sel_pin_q <= pin_bits_i[2];
      regnum_q  <= regnum_d;
      // Load the addressed register; register 31 drops the write
      if (load) begin
        if (regnum_q < REG_RTAP_BASE) begin
          ltap_q[regnum_q[2:0]] <= gain_lookup(shifted);
        end else if (regnum_q < REG_VOL_BASE) begin
          rtap_q[regnum_q[2:0]] <= gain_lookup(shifted);
        end else if (regnum_q < REG_COEF_BASE) begin
          vol_q[regnum_q[1:0]] <= gain_lookup(shifted);
        end else if (regnum_q < REG_TAP_BASE) begin
          coef_q[regnum_q[0]] <= signed'({shifted, 6'd0});
        end else if (regnum_q < REG_NONE) begin
          off_q[4'(regnum_q - REG_TAP_BASE)] <= OFF_W'(OFF_W'(shifted[4:0])
                                                       * OFF_W'(TAP_STEP));
        end
      end
    end
  end

  assign ltap_o = ltap_q;
  assign rtap_o = rtap_q;
  assign vol_o  = vol_q;
  assign coef_o = coef_q;
  assign off_o  = off_q;

endmodule

// ===== rtl/core/sdp_mul.sv =====
// ----------------------------------------------------------------------------
// sdp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module sdp_mul import sdp_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // Register the product for the next step of the sequencer
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule
